[hdl/rbss_pkg.sv]
`timescale 1ns / 1ps

package rbss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W    = 10;
    localparam int RADIUS_W   = 9;
    localparam int COLOUR_W   = 16;
    localparam int SPAN_X_W   = 11;
    localparam int ROW_OUT_W  = 6;
    localparam int SQ_W       = 2 * RADIUS_W;
    localparam int REM_W      = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LEFT      = 3'd0,
        CFG_BOX_TOP       = 3'd1,
        CFG_BOX_WIDTH     = 3'd2,
        CFG_BOX_HEIGHT    = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOUR   = 3'd5,
        CFG_BORDER_COLOUR = 3'd6
    } t_cfg_idx;

    // Partial result of the digit-by-digit square root.
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [RADIUS_W-1:0] root;
    } t_sqrt;

    localparam t_sqrt SQRT_ZERO = '{rem: '0, root: '0};

endpackage

[hdl/rounded_box_strip_spans_top.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+---------------------------------
// request   | in        | start high while busy low      | i_strip_top
// span      | out       | o_span_valid, one cycle each   | o_strip_row .. o_last_span
// config    | in        | i_cfg_we, no wait              | i_cfg_idx, i_cfg_wdata
//
// A request keeps busy high while it is being processed: the row sequencer
// issues one strip row per cycle into an eight-stage span pipeline (square root in three
// stages), and one span is held back so that the last one can be marked.
// Spans appear at most one per cycle; the receiver cannot stall them.
// Reset is synchronous and active low; it resets the config registers and control flags.
module rounded_box_strip_spans_top
    import rbss_pkg::*;
#(
    parameter int ROWS_PER_STRIP = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    i_strip_top,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_span_valid,
    output logic [ROW_OUT_W-1:0]  o_strip_row,
    output logic [SPAN_X_W-1:0]   o_span_left,
    output logic [SPAN_X_W-1:0]   o_span_right,
    output logic                  o_edge_row,
    output logic [COLOUR_W-1:0]   o_span_fill,
    output logic [COLOUR_W-1:0]   o_span_border,
    output logic                  o_last_span
);

    localparam int CNT_W = (ROWS_PER_STRIP > 1) ? $clog2(ROWS_PER_STRIP) : 1;
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(ROWS_PER_STRIP - 1);

    function automatic t_sqrt sqrt_step(input t_sqrt s, input logic [1:0] pair);
        logic [REM_W-1:0] rem_s;
        logic [REM_W-1:0] trial;
        t_sqrt            res;
        rem_s = {s.rem[REM_W-3:0], pair};
        trial = {1'b0, s.root, 2'b01};
        if (rem_s >= trial) begin
            res.rem  = rem_s - trial;
            res.root = {s.root[RADIUS_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_s;
            res.root = {s.root[RADIUS_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // Configuration registers.
    logic [COORD_W-1:0]  r_box_left, r_box_top, r_box_width, r_box_height;
    logic [RADIUS_W-1:0] r_corner_radius;
    logic [COLOUR_W-1:0] r_fill_colour, r_border_colour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left      <= '0;
            r_box_top       <= '0;
            r_box_width     <= COORD_W'(1);
            r_box_height    <= COORD_W'(1);
            r_corner_radius <= '0;
            r_fill_colour   <= '0;
            r_border_colour <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_LEFT:      r_box_left      <= i_cfg_wdata[COORD_W-1:0];
                CFG_BOX_TOP:       r_box_top       <= i_cfg_wdata[COORD_W-1:0];
                CFG_BOX_WIDTH:     r_box_width     <= i_cfg_wdata[COORD_W-1:0];
                CFG_BOX_HEIGHT:    r_box_height    <= i_cfg_wdata[COORD_W-1:0];
                CFG_CORNER_RADIUS: r_corner_radius <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_FILL_COLOUR:   r_fill_colour   <= i_cfg_wdata[COLOUR_W-1:0];
                CFG_BORDER_COLOUR: r_border_colour <= i_cfg_wdata[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Row sequencer.
    logic               r_active;
    logic [CNT_W-1:0]   r_row;
    logic [COORD_W-1:0] r_strip_top;
    logic               w_accept;
    logic               w_seq_final;

    assign w_accept    = start && !busy;
    assign w_seq_final = (r_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_accept) begin
            r_active <= 1'b1;
        end else if (r_active && w_seq_final) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row       <= '0;
            r_strip_top <= i_strip_top;
        end else if (r_active) begin
            r_row <= r_row + CNT_W'(1);
        end
    end

    // Stage 1: screen row, box membership and distances from both edges.
    logic [SPAN_X_W-1:0] n1_screen_y, n1_top_end, n1_ry, n1_ryb;
    logic                n1_inbox;
    logic                r1_valid, r1_final, r1_inbox;
    logic [CNT_W-1:0]    r1_row;
    logic [COORD_W-1:0]  r1_ry, r1_ryb;

    always_comb begin
        n1_screen_y = {1'b0, r_strip_top} + SPAN_X_W'(r_row);
        n1_top_end  = {1'b0, r_box_top} + {1'b0, r_box_height};
        n1_inbox    = (n1_screen_y >= {1'b0, r_box_top}) && (n1_screen_y < n1_top_end);
        n1_ry       = n1_screen_y - {1'b0, r_box_top};
        n1_ryb      = n1_top_end - n1_screen_y - SPAN_X_W'(1);
    end

    always_ff @(posedge i_clk) begin
        r1_final <= w_seq_final;
        r1_row   <= r_row;
        r1_inbox <= n1_inbox;
        r1_ry    <= n1_ry[COORD_W-1:0];
        r1_ryb   <= n1_ryb[COORD_W-1:0];
    end

    // Stage 2: corner band selection. The top band wins where the two overlap.
    logic                n2_top_band, n2_bot_band;
    logic [RADIUS_W-1:0] n2_dist;
    logic                r2_valid, r2_final, r2_inbox, r2_corner, r2_edge;
    logic [CNT_W-1:0]    r2_row;
    logic [RADIUS_W-1:0] r2_dy;

    always_comb begin
        n2_top_band = r1_ry < {1'b0, r_corner_radius};
        n2_bot_band = r1_ryb < {1'b0, r_corner_radius};
        n2_dist     = n2_top_band ? r1_ry[RADIUS_W-1:0] : r1_ryb[RADIUS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r2_final  <= r1_final;
        r2_row    <= r1_row;
        r2_inbox  <= r1_inbox;
        r2_corner <= n2_top_band || n2_bot_band;
        r2_edge   <= (r1_ry == '0) || (r1_ryb == '0);
        r2_dy     <= r_corner_radius - n2_dist;
    end

    // Stage 3: squares.
    logic                r3_valid, r3_final, r3_inbox, r3_corner, r3_edge;
    logic [CNT_W-1:0]    r3_row;
    logic [SQ_W-1:0]     r3_rr, r3_dd;

    always_ff @(posedge i_clk) begin
        r3_final  <= r2_final;
        r3_row    <= r2_row;
        r3_inbox  <= r2_inbox;
        r3_corner <= r2_corner;
        r3_edge   <= r2_edge;
        r3_rr     <= SQ_W'(r_corner_radius) * SQ_W'(r_corner_radius);
        r3_dd     <= SQ_W'(r2_dy) * SQ_W'(r2_dy);
    end

    // Stage 4: radicand.
    logic                r4_valid, r4_final, r4_inbox, r4_corner, r4_edge;
    logic [CNT_W-1:0]    r4_row;
    logic [SQ_W-1:0]     r4_v;

    always_ff @(posedge i_clk) begin
        r4_final  <= r3_final;
        r4_row    <= r3_row;
        r4_inbox  <= r3_inbox;
        r4_corner <= r3_corner;
        r4_edge   <= r3_edge;
        r4_v      <= r3_rr - r3_dd;
    end

    // Stages 5 to 7: square root, three result bits per stage.
    logic             r5_valid, r5_final, r5_inbox, r5_corner, r5_edge;
    logic [CNT_W-1:0] r5_row;
    t_sqrt            r5_sq;
    logic [11:0]      r5_v_lo;

    always_ff @(posedge i_clk) begin
        r5_final  <= r4_final;
        r5_row    <= r4_row;
        r5_inbox  <= r4_inbox;
        r5_corner <= r4_corner;
        r5_edge   <= r4_edge;
        r5_sq     <= sqrt_step(sqrt_step(sqrt_step(SQRT_ZERO, r4_v[17:16]),
                                         r4_v[15:14]), r4_v[13:12]);
        r5_v_lo   <= r4_v[11:0];
    end

    logic             r6_valid, r6_final, r6_inbox, r6_corner, r6_edge;
    logic [CNT_W-1:0] r6_row;
    t_sqrt            r6_sq;
    logic [5:0]       r6_v_lo;

    always_ff @(posedge i_clk) begin
        r6_final  <= r5_final;
        r6_row    <= r5_row;
        r6_inbox  <= r5_inbox;
        r6_corner <= r5_corner;
        r6_edge   <= r5_edge;
        r6_sq     <= sqrt_step(sqrt_step(sqrt_step(r5_sq, r5_v_lo[11:10]),
                                         r5_v_lo[9:8]), r5_v_lo[7:6]);
        r6_v_lo   <= r5_v_lo[5:0];
    end

    logic                r7_valid, r7_final, r7_inbox, r7_corner, r7_edge;
    logic [CNT_W-1:0]    r7_row;
    t_sqrt               n7_sq;
    logic [RADIUS_W-1:0] r7_root;

    assign n7_sq = sqrt_step(sqrt_step(sqrt_step(r6_sq, r6_v_lo[5:4]),
                                       r6_v_lo[3:2]), r6_v_lo[1:0]);

    always_ff @(posedge i_clk) begin
        r7_final  <= r6_final;
        r7_row    <= r6_row;
        r7_inbox  <= r6_inbox;
        r7_corner <= r6_corner;
        r7_edge   <= r6_edge;
        r7_root   <= n7_sq.root;
    end

    // Stage 8: inset, width test and span ends.
    logic [RADIUS_W-1:0] n8_inset;
    logic                r8_valid, r8_final, r8_span, r8_edge;
    logic [CNT_W-1:0]    r8_row;
    logic [SPAN_X_W-1:0] r8_left, r8_right;

    assign n8_inset = r7_corner ? (r_corner_radius - r7_root) : '0;

    always_ff @(posedge i_clk) begin
        r8_final <= r7_final;
        r8_row   <= r7_row;
        r8_edge  <= r7_edge;
        r8_span  <= r7_inbox && ({1'b0, r_box_width} > {1'b0, n8_inset, 1'b0});
        r8_left  <= {1'b0, r_box_left} + {2'b0, n8_inset};
        r8_right <= {1'b0, r_box_left} + {1'b0, r_box_width} - SPAN_X_W'(1)
                    - {2'b0, n8_inset};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            r1_valid <= r_active;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    // One span is held back until the next one, or the end of the strip, shows
    // whether it is the last.
    logic                r_pend_valid, r_flush;
    logic [CNT_W-1:0]    r_pend_row;
    logic [SPAN_X_W-1:0] r_pend_left, r_pend_right;
    logic                r_pend_edge;
    logic                n_pend_valid, n_pend_load, n_flush, n_out_valid, n_out_last;
    logic                r_out_valid, r_out_last, r_out_edge;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [SPAN_X_W-1:0] r_out_left, r_out_right;
    logic [COLOUR_W-1:0] r_out_fill, r_out_border;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_load  = 1'b0;
        n_flush      = 1'b0;
        n_out_valid  = 1'b0;
        n_out_last   = 1'b0;
        if (r_flush) begin
            n_out_valid  = 1'b1;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end else if (r8_valid) begin
            if (r8_span) begin
                n_out_valid  = r_pend_valid;
                n_pend_load  = 1'b1;
                n_pend_valid = 1'b1;
                n_flush      = r8_final;
            end else if (r8_final && r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_flush      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_flush      <= n_flush;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_pend_load) begin
            r_pend_row   <= r8_row;
            r_pend_left  <= r8_left;
            r_pend_right <= r8_right;
            r_pend_edge  <= r8_edge;
        end
        if (n_out_valid) begin
            r_out_last   <= n_out_last;
            r_out_row    <= ROW_OUT_W'(r_pend_row);
            r_out_left   <= r_pend_left;
            r_out_right  <= r_pend_right;
            r_out_edge   <= r_pend_edge;
            r_out_fill   <= r_fill_colour;
            r_out_border <= r_border_colour;
        end
    end

    assign busy = r_active || r1_valid || r2_valid || r3_valid || r4_valid || r5_valid
                  || r6_valid || r7_valid || r8_valid || r_pend_valid || r_flush;

    assign o_span_valid  = r_out_valid;
    assign o_strip_row   = r_out_row;
    assign o_span_left   = r_out_left;
    assign o_span_right  = r_out_right;
    assign o_edge_row    = r_out_edge;
    assign o_span_fill   = r_out_fill;
    assign o_span_border = r_out_border;
    assign o_last_span   = r_out_last;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low after a request was taken");

    a_flush_has_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_pend_valid)
        else $error("end-of-strip flush with no held span");

    a_span_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span_valid |-> (o_span_left <= o_span_right))
        else $error("span left end beyond right end");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_valid && o_last_span) |=> !o_span_valid)
        else $error("span directly after the last span of a strip");

    a_pend_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !r_flush && !r8_valid) |-> (r1_valid || r2_valid || r3_valid
            || r4_valid || r5_valid || r6_valid || r7_valid || r_active))
        else $error("held span stranded with no rows left in flight");
`endif

endmodule
